// File: rtl/core/ffba_pkg.sv
// Shared types and constants of the first-fit block allocator.
package ffba_pkg;

    localparam int FIELD_W    = 11;
    localparam int STATUS_W   = 3;
    localparam int ALIGN_BITS = 3;
    localparam int ALIGN_ADD  = 7;

    typedef enum logic [STATUS_W-1:0] {
        ST_NEW       = 3'd0,
        ST_REUSED    = 3'd1,
        ST_OOM       = 3'd2,
        ST_FREED     = 3'd3,
        ST_NULL      = 3'd4,
        ST_NOT_FOUND = 3'd5
    } ffba_status_t;

    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } ffba_func_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_APPEND,
        S_DONE
    } ffba_state_t;

endpackage

// File: rtl/core/first_fit_block_allocator_unit.sv
// Top level of the first-fit block allocator.
//
//   Channel | Direction | Handshake            | Beat contents
//   --------+-----------+----------------------+-------------------------------------
//   in      | inbound   | in_valid / in_ready  | func, request_size, address
//   out     | outbound  | out_valid / out_ready| status, address_out, block_size
//
// One beat is worked on at a time. A null free skips the table scan and goes straight to
// the done state; its result is loaded once the output register is free. Any other beat
// scans the table entries in order: a hit ends the scan at once, a miss ends it after the
// last entry, and an allocate miss then passes through the append state. The next beat is
// accepted once the result has moved to the output register. The scan is paced by the
// single read port of the block table, which returns one entry per cycle as registered
// read data; reads are issued back to back so the scan runs at a full entry per cycle.
// Reset clears the entry count, the bump offset and the output valid flag. The table
// itself is not cleared: only entries below the count are read, and each of those has
// been written. A result waiting in the output register does not stop the next beat
// from being accepted; the scan then holds its result until the register is free.
//
// The table holds, per block, its start offset, the stored payload size and a free
// mark. An allocate beat reuses the first free block large enough, without splitting
// it, else appends a block of header plus request, rounded up to eight bytes, at the
// bump offset, else reports out of memory (also when the table is full). A free beat
// marks the block whose payload offset matches; an unknown offset is reported rather
// than acted on, and an address of zero is ignored.
module first_fit_block_allocator_unit
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES   = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [FIELD_W-1:0]  request_size,
    input  logic [FIELD_W-1:0]  address,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [FIELD_W-1:0]  address_out,
    output logic [FIELD_W-1:0]  block_size
);

    // Offsets run from zero up to the pool size itself (the bump offset of a full pool).
    localparam int OFF_W  = $clog2(POOL_BYTES + 1);
    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int DATA_W = OFF_W + FIELD_W + 1;

    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;

    ffba_ctrl #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .OFF_W        (OFF_W),
        .IDX_W        (IDX_W),
        .CNT_W        (CNT_W),
        .DATA_W       (DATA_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .request_size (request_size),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .address_out  (address_out),
        .block_size   (block_size),
        .rd_en        (rd_en),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data)
    );

    // The free mark is only ever written in the cycle after its entry was read, and the
    // next scan starts only after that write, so reads never see a stale entry.
    ffba_table #(
        .DEPTH  (MAX_BLOCKS),
        .IDX_W  (IDX_W),
        .DATA_W (DATA_W)
    ) u_table (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

endmodule

// File: rtl/core/ffba_table.sv
// Block table memory: one write port, one read port with registered read data.
module ffba_table
    import ffba_pkg::*;
#(
    parameter int DEPTH  = 64,
    parameter int IDX_W  = 6,
    parameter int DATA_W = 23
)
(
    input  logic              clk,
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic [DATA_W-1:0] rd_data,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/core/ffba_ctrl.sv
// Allocator sequencer: table scan, append arithmetic and result register.
module ffba_ctrl
    import ffba_pkg::*;
#(
    parameter int POOL_BYTES   = 1024,
    parameter int HEADER_BYTES = 24,
    parameter int MAX_BLOCKS   = 64,
    parameter int OFF_W        = 11,
    parameter int IDX_W        = 6,
    parameter int CNT_W        = 7,
    parameter int DATA_W       = 23
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                func,
    input  logic [FIELD_W-1:0]  request_size,
    input  logic [FIELD_W-1:0]  address,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [FIELD_W-1:0]  address_out,
    output logic [FIELD_W-1:0]  block_size,
    output logic                rd_en,
    output logic [IDX_W-1:0]    rd_addr,
    input  logic [DATA_W-1:0]   rd_data,
    output logic                wr_en,
    output logic [IDX_W-1:0]    wr_addr,
    output logic [DATA_W-1:0]   wr_data
);

    localparam int SUM_W = ((OFF_W > FIELD_W) ? OFF_W : FIELD_W) + 2;

    ffba_state_t         state_reg, state_next;
    logic                func_reg, func_next;
    logic [FIELD_W-1:0]  req_reg, req_next;
    logic [FIELD_W-1:0]  addr_reg, addr_next;
    logic [CNT_W-1:0]    issue_reg, issue_next;
    logic [IDX_W-1:0]    chk_idx_reg, chk_idx_next;
    logic                pend_reg, pend_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [OFF_W-1:0]    bump_reg, bump_next;
    ffba_status_t        res_status_reg, res_status_next;
    logic [FIELD_W-1:0]  res_addr_reg, res_addr_next;
    logic [FIELD_W-1:0]  res_size_reg, res_size_next;
    logic                out_valid_reg, out_valid_next;
    ffba_status_t        out_status_reg, out_status_next;
    logic [FIELD_W-1:0]  out_addr_reg, out_addr_next;
    logic [FIELD_W-1:0]  out_size_reg, out_size_next;

    logic [OFF_W-1:0]    ent_start;
    logic [FIELD_W-1:0]  ent_size;
    logic                ent_free;
    logic [SUM_W-1:0]    pay_addr;
    logic                alloc_hit;
    logic                free_hit;
    logic                hit;
    logic                exhausted;
    logic [SUM_W-1:0]    new_sum;
    logic [SUM_W-1:0]    total;
    logic [SUM_W-1:0]    end_sum;
    logic [SUM_W-1:0]    new_pay;
    logic                fits;
    logic                in_accept;
    logic                out_free;

    assign ent_start = rd_data[DATA_W-1 -: OFF_W];
    assign ent_size  = rd_data[1 +: FIELD_W];
    assign ent_free  = rd_data[0];

    assign pay_addr  = SUM_W'(ent_start) + SUM_W'(HEADER_BYTES);
    assign alloc_hit = ent_free && (ent_size >= req_reg);
    assign free_hit  = (pay_addr == SUM_W'(addr_reg));
    assign hit       = pend_reg && ((func_reg == FUNC_FREE) ? free_hit : alloc_hit);
    assign exhausted = !pend_reg && (issue_reg >= count_reg);

    // New block: header plus request, rounded up to the alignment.
    assign new_sum = SUM_W'(HEADER_BYTES) + SUM_W'(req_reg) + SUM_W'(ALIGN_ADD);
    assign total   = {new_sum[SUM_W-1:ALIGN_BITS], {ALIGN_BITS{1'b0}}};
    assign end_sum = SUM_W'(bump_reg) + total;
    assign new_pay = SUM_W'(bump_reg) + SUM_W'(HEADER_BYTES);
    assign fits    = (count_reg < CNT_W'(MAX_BLOCKS)) && (end_sum <= SUM_W'(POOL_BYTES));

    assign in_ready  = (state_reg == S_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if ((func == FUNC_FREE) && (address == '0))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = S_DONE;
                end
                else if (exhausted)
                begin
                    state_next = (func_reg == FUNC_FREE) ? S_DONE : S_APPEND;
                end
            end
            S_APPEND:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        func_next       = func_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        issue_next      = issue_reg;
        chk_idx_next    = chk_idx_reg;
        pend_next       = 1'b0;
        count_next      = count_reg;
        bump_next       = bump_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_size_next   = res_size_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        out_size_next   = out_size_reg;
        rd_en           = 1'b0;
        rd_addr         = issue_reg[IDX_W-1:0];
        wr_en           = 1'b0;
        wr_addr         = chk_idx_reg;
        wr_data         = {ent_start, ent_size, (func_reg == FUNC_FREE)};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    func_next       = func;
                    req_next        = request_size;
                    addr_next       = address;
                    issue_next      = '0;
                    res_status_next = ST_NULL;
                    res_addr_next   = '0;
                    res_size_next   = '0;
                end
            end
            S_SCAN:
            begin
                if (issue_reg < count_reg)
                begin
                    rd_en        = 1'b1;
                    pend_next    = 1'b1;
                    chk_idx_next = issue_reg[IDX_W-1:0];
                    issue_next   = issue_reg + CNT_W'(1);
                end
                if (hit)
                begin
                    wr_en         = 1'b1;
                    res_size_next = ent_size;
                    if (func_reg == FUNC_FREE)
                    begin
                        res_status_next = ST_FREED;
                        res_addr_next   = '0;
                    end
                    else
                    begin
                        res_status_next = ST_REUSED;
                        res_addr_next   = pay_addr[FIELD_W-1:0];
                    end
                end
                else if (exhausted)
                begin
                    res_status_next = ST_NOT_FOUND;
                    res_addr_next   = '0;
                    res_size_next   = '0;
                end
            end
            S_APPEND:
            begin
                if (fits)
                begin
                    wr_en           = 1'b1;
                    wr_addr         = count_reg[IDX_W-1:0];
                    wr_data         = {bump_reg, req_reg, 1'b0};
                    count_next      = count_reg + CNT_W'(1);
                    bump_next       = end_sum[OFF_W-1:0];
                    res_status_next = ST_NEW;
                    res_addr_next   = new_pay[FIELD_W-1:0];
                    res_size_next   = req_reg;
                end
                else
                begin
                    res_status_next = ST_OOM;
                    res_addr_next   = '0;
                    res_size_next   = '0;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_addr_next   = res_addr_reg;
                    out_size_next   = res_size_reg;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_reg      <= 1'b0;
            count_reg     <= '0;
            bump_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pend_reg      <= pend_next;
            count_reg     <= count_next;
            bump_reg      <= bump_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        issue_reg      <= issue_next;
        chk_idx_reg    <= chk_idx_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_size_reg   <= res_size_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
        out_size_reg   <= out_size_next;
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign address_out = out_addr_reg;
    assign block_size  = out_size_reg;

endmodule

// File: sim/tb_first_fit_block_allocator_unit.sv
// Self-checking testbench for the first-fit block allocator, with directed and random traffic.
module tb_first_fit_block_allocator_unit;
    import ffba_pkg::*;

    // The block is built with its default sizes. With a 1024-byte pool every block takes at
    // least 24 bytes, so no more than 42 blocks can ever exist. The table-full case (64
    // blocks) cannot be reached at these sizes, so the pool always runs out first.
    localparam int POOL_BYTES   = 1024;
    localparam int HEADER_BYTES = 24;
    localparam int MAX_BLOCKS   = 64;
    localparam int FIELD_TOP    = 1024;
    localparam int RANDOM_BEATS = 1800;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int MAX_REPORTS  = 10;

    typedef logic [FIELD_W-1:0] field_t;

    // What one beat on the result channel should carry.
    typedef struct packed {
        ffba_status_t status;
        field_t       addr;
        field_t       size;
    } outcome_t;

    // Every input of the block is known from time zero.
    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic                func = FUNC_ALLOC;
    field_t              request_size = '0;
    field_t              address = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    field_t              address_out;
    field_t              block_size;

    // Our own picture of the pool: the block table, its fill level and the bump offset.
    int unsigned blk_start [MAX_BLOCKS];
    int unsigned blk_size  [MAX_BLOCKS];
    bit          blk_free  [MAX_BLOCKS];
    int unsigned blk_count = 0;
    int unsigned bump_offset = 0;

    // Outcomes predicted at acceptance and not yet seen on the result channel.
    outcome_t awaited_outcomes[$];

    int error_count = 0;
    int cycle_count = 0;
    int burst_left = 0;
    int ready_mode = 0;
    int ready_mode_left = 0;

    first_fit_block_allocator_unit #(
        .POOL_BYTES   (POOL_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .request_size (request_size),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .address_out  (address_out),
        .block_size   (block_size)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Applies one accepted beat to the pool picture and returns the outcome it must give.
    // Allocation walks the table in address order and takes the first free block that is
    // big enough, keeping its stored size; failing that it appends a block whose span is
    // header plus request rounded up to eight bytes. A free marks the block whose payload
    // offset matches, even if it is already free.
    function automatic outcome_t pool_outcome(input ffba_func_t op, input int unsigned req,
                                              input int unsigned addr);
        outcome_t    res;
        int unsigned span;
        res.status = ST_NOT_FOUND;
        res.addr   = '0;
        res.size   = '0;
        if (op == FUNC_ALLOC)
        begin
            for (int i = 0; i < blk_count; i++)
            begin
                if (blk_free[i] && blk_size[i] >= req)
                begin
                    blk_free[i] = 1'b0;
                    res.status  = ST_REUSED;
                    res.addr    = field_t'(blk_start[i] + HEADER_BYTES);
                    res.size    = field_t'(blk_size[i]);
                    return res;
                end
            end
            span = ((HEADER_BYTES + req + ALIGN_ADD) >> ALIGN_BITS) << ALIGN_BITS;
            if (blk_count >= MAX_BLOCKS || bump_offset + span > POOL_BYTES)
            begin
                res.status = ST_OOM;
                return res;
            end
            blk_start[blk_count] = bump_offset;
            blk_size[blk_count]  = req;
            blk_free[blk_count]  = 1'b0;
            blk_count++;
            res.status  = ST_NEW;
            res.addr    = field_t'(bump_offset + HEADER_BYTES);
            res.size    = field_t'(req);
            bump_offset += span;
            return res;
        end
        if (addr == 0)
        begin
            res.status = ST_NULL;
            return res;
        end
        for (int i = 0; i < blk_count; i++)
        begin
            if (blk_start[i] + HEADER_BYTES == addr)
            begin
                blk_free[i] = 1'b1;
                res.status  = ST_FREED;
                res.size    = field_t'(blk_size[i]);
                return res;
            end
        end
        return res;
    endfunction

    // Payload offset of an existing block, as a caller would hold it.
    function automatic field_t payload_of(input int unsigned idx);
        return field_t'(blk_start[idx] + HEADER_BYTES);
    endfunction

    // Both channels are sampled at the rising edge, before the testbench's own nonblocking
    // updates land, so the values seen here are the ones the block saw. An accepted input
    // beat is predicted first, then any result beat is checked against the oldest
    // prediction. A result is loaded only from the done state, which a beat reaches after its
    // acceptance, so a result never belongs to the beat accepted at the same edge.
    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                awaited_outcomes.push_back(pool_outcome(ffba_func_t'(func), request_size,
                                                        address));
            if (out_valid && out_ready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("result beat with nothing awaited: status %0d addr %0d size %0d",
                                 status, address_out, block_size);
                end
                else
                begin
                    want = awaited_outcomes.pop_front();
                    if (status !== want.status || address_out !== want.addr ||
                        block_size !== want.size)
                    begin
                        error_count++;
                        if (error_count <= MAX_REPORTS)
                            $display({"result mismatch: status exp %0d got %0d, address_out ",
                                      "exp %0d got %0d, block_size exp %0d got %0d"},
                                     want.status, status, want.addr, address_out,
                                     want.size, block_size);
                    end
                end
            end
        end
    end

    // The receiver switches at random among four manners: always ready, mostly ready, a coin
    // toss, or a fixed rhythm that is ready one quarter of the time. The always-ready phases
    // give stretches with no back-pressure at all.
    always @(posedge clk)
    begin
        if (ready_mode_left == 0)
        begin
            ready_mode      <= $urandom_range(0, 3);
            ready_mode_left <= $urandom_range(20, 200);
        end
        else
        begin
            ready_mode_left <= ready_mode_left - 1;
        end
        case (ready_mode)
            0:
            begin
                out_ready <= 1'b1;
            end
            1:
            begin
                out_ready <= ($urandom_range(0, 3) != 0);
            end
            2:
            begin
                out_ready <= ($urandom_range(0, 1) != 0);
            end
            default:
            begin
                out_ready <= ((ready_mode_left % 16) < 4);
            end
        endcase
    end

    // A hung block must not hold the run forever.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_first_fit_block_allocator_unit: done, errors");
            $finish;
        end
    end

    // Sends one beat. The sender works in bursts: at the start of each burst it may drop
    // valid for a random gap, otherwise valid stays high from one beat straight into the
    // next. The task returns at the edge where the beat was taken, with valid still high.
    task automatic send_beat(input ffba_func_t op, input int unsigned req,
                             input int unsigned addr);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid     <= 1'b1;
        func         <= op;
        request_size <= field_t'(req);
        address      <= field_t'(addr);
        do @(posedge clk); while (!in_ready);
    endtask

    // An empty pool: a null free is ignored, and no address can be found yet, including
    // the first payload offset and an offset equal to the pool size.
    task automatic test_empty_pool();
        send_beat(FUNC_FREE, FIELD_TOP, 0);
        send_beat(FUNC_FREE, 0, FIELD_TOP);
        send_beat(FUNC_FREE, 0, HEADER_BYTES);
    endtask

    // Appending: a zero-size request still takes a header's worth of pool, sizes either side
    // of the eight-byte rounding, and a request of the whole pool, which cannot fit.
    task automatic test_append_blocks();
        send_beat(FUNC_ALLOC, 0, 0);
        send_beat(FUNC_ALLOC, 1, FIELD_TOP);
        send_beat(FUNC_ALLOC, 7, 0);
        send_beat(FUNC_ALLOC, 8, 0);
        send_beat(FUNC_ALLOC, FIELD_TOP, 0);
        send_beat(FUNC_ALLOC, 100, 0);
    endtask

    // Freeing and reuse. The zero-size block is freed twice (the second time it is already
    // free), then the one-byte block. A one-byte request must skip the zero-size block and
    // take the next, a zero-size request then takes the first, and a further one finds
    // nothing free and appends. An offset inside a block is not a payload offset.
    task automatic test_free_and_reuse();
        send_beat(FUNC_FREE, 0, payload_of(0));
        send_beat(FUNC_FREE, 0, payload_of(0));
        send_beat(FUNC_FREE, FIELD_TOP, payload_of(1));
        send_beat(FUNC_ALLOC, 1, 0);
        send_beat(FUNC_ALLOC, 0, 0);
        send_beat(FUNC_ALLOC, 0, 0);
        send_beat(FUNC_FREE, 0, payload_of(0) + 1);
    endtask

    // Filling the pool: the second append ends exactly at the last pool byte, so even a
    // zero-size request after it runs out of memory.
    task automatic test_pool_exhaustion();
        send_beat(FUNC_ALLOC, 600, 0);
        send_beat(FUNC_ALLOC, 104, 0);
        send_beat(FUNC_ALLOC, 0, 0);
    endtask

    // Random traffic. Most frees name a block that exists, so reuse and double frees keep
    // happening once the pool is full; the rest are unknown offsets and null frees. Most
    // requests are small, with a tail up to the pool size. The field a beat does not use
    // carries a random value.
    task automatic test_random_traffic(input int beats);
        int          pick;
        int unsigned req;
        for (int n = 0; n < beats; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
            begin
                if ($urandom_range(0, 9) < 7)
                    req = $urandom_range(0, 48);
                else if ($urandom_range(0, 1) == 0)
                    req = $urandom_range(49, 200);
                else
                    req = $urandom_range(0, FIELD_TOP);
                send_beat(FUNC_ALLOC, req, $urandom_range(0, FIELD_TOP));
            end
            else if (pick < 85)
            begin
                if (blk_count > 0)
                    send_beat(FUNC_FREE, $urandom_range(0, FIELD_TOP),
                              payload_of($urandom_range(0, blk_count - 1)));
                else
                    send_beat(FUNC_FREE, $urandom_range(0, FIELD_TOP), 0);
            end
            else if (pick < 93)
            begin
                send_beat(FUNC_FREE, $urandom_range(0, FIELD_TOP),
                          $urandom_range(1, FIELD_TOP));
            end
            else if (pick < 97)
            begin
                send_beat(FUNC_FREE, $urandom_range(0, FIELD_TOP), 0);
            end
            else
            begin
                send_beat(FUNC_ALLOC, $urandom_range(POOL_BYTES - 64, FIELD_TOP),
                          $urandom_range(0, FIELD_TOP));
            end
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_pool();
        test_append_blocks();
        test_free_and_reuse();
        test_pool_exhaustion();
        test_random_traffic(RANDOM_BEATS);
        in_valid <= 1'b0;

        // Let every awaited result come out, then give the block time to show any stray one.
        while (awaited_outcomes.size() != 0)
            @(posedge clk);
        repeat (MAX_BLOCKS + 8) @(posedge clk);

        if (error_count == 0)
            $display("tb_first_fit_block_allocator_unit: done, clean");
        else
            $display("tb_first_fit_block_allocator_unit: done, errors");
        $finish;
    end

endmodule

// File: first_fit_block_allocator_unit.f
rtl/core/ffba_pkg.sv
rtl/core/ffba_table.sv
rtl/core/ffba_ctrl.sv
rtl/core/first_fit_block_allocator_unit.sv
sim/tb_first_fit_block_allocator_unit.sv
